[rtl/pctc_pkg.sv]
package pctc_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int DIV_INT_MAX = 16777215;
	localparam int VCO_MIN_HZ  = 750000000;
	localparam int VCO_MAX_HZ  = 1600000000;

	localparam int HZ_W     = 31;
	localparam int AMOUNT_W = 64;
	localparam int PROD_W   = 32 + HZ_W;
	localparam int DVD_W    = AMOUNT_W + HZ_W;
	localparam int CRYS_W   = 24;
	localparam int VCO_W    = CRYS_W + 9;
	localparam int SDEN_W   = 24 + FRAC_BITS;
	localparam int SNUM_W   = 32 + FRAC_BITS;
	localparam int SCNT_W   = $clog2(SNUM_W);

	localparam logic [HZ_W-1:0] NS_PER_S = HZ_W'(1000000000);
	localparam logic [HZ_W-1:0] US_PER_S = HZ_W'(1000000);

	localparam logic [CRYS_W-1:0] CRYS_MIN_HZ = CRYS_W'(1000000);
	localparam logic [CRYS_W-1:0] CRYS_MAX_HZ = CRYS_W'(15000000);
	localparam logic [CRYS_W-1:0] REF_MIN_HZ  = CRYS_W'(5000000);
	localparam logic [8:0]        FB_MIN      = 9'd16;
	localparam logic [8:0]        FB_MAX      = 9'd320;

	typedef enum logic [1:0] {
		OP_TICKS_TO_NS = 2'd0,
		OP_TICKS_TO_US = 2'd1,
		OP_NS_TO_TICKS = 2'd2,
		OP_US_TO_TICKS = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_CRYSTAL = 3'd1,
		ST_DIVIDER = 3'd2,
		ST_REFDIV  = 3'd3,
		ST_FBDIV   = 3'd4,
		ST_VCO     = 3'd5,
		ST_POSTDIV = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_CRYSTAL  = 3'd0,
		REG_REF_DIV  = 3'd1,
		REG_FB_DIV   = 3'd2,
		REG_POST_ONE = 3'd3,
		REG_POST_TWO = 3'd4,
		REG_BYPASS   = 3'd5,
		REG_DIV_INT  = 3'd6,
		REG_DIV_FRAC = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		CAL_LOAD_REF,
		CAL_REF_DIV,
		CAL_VCO,
		CAL_POST_DIV,
		CAL_SYS_LOAD,
		CAL_SYS_DIV,
		CAL_IDLE
	} cal_state_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [AMOUNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [AMOUNT_W-1:0] converted;
		logic [HZ_W-1:0]     system_hz;
		logic [2:0]          status;
		logic                overflow;
	} rsp_t;

	typedef struct packed {
		logic            zero;
		logic [HZ_W-1:0] den;
		logic [HZ_W-1:0] rem;
		logic [DVD_W-1:0] num;
	} dstage_t;

endpackage

[rtl/pll_clock_tree_time_converter_unit.sv]
// Clock-tree time converter. After reset and after every configuration write the block
// recomputes the tree status and system frequency with one shared bit-serial divider
// (three 40-bit divisions, each after its own setup state) and holds req_stall
// high meanwhile. After that it takes one transaction every cycle while the pipeline
// is not frozen: each conversion is rewritten as one division floor((amount*M + A)/D),
// formed by a two-stage 32-bit partial-product multiplier and finished by a 95-stage
// pipelined restoring divider, one quotient bit per stage. A held rsp_stall freezes
// the whole pipeline.
module pll_clock_tree_time_converter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pctc_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pctc_pkg::rsp_t      rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data
);

	localparam int NST = pctc_pkg::DVD_W;

	// configuration registers
	logic [23:0] crystal_q;
	logic [5:0]  ref_div_q;
	logic [8:0]  fb_div_q;
	logic [2:0]  post_one_q;
	logic [2:0]  post_two_q;
	logic        bypass_q;
	logic [23:0] div_int_q;
	logic [15:0] div_frac_q;

	logic cfg_wr;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q  <= 24'd12000000;
			ref_div_q  <= 6'd1;
			fb_div_q   <= 9'd125;
			post_one_q <= 3'd6;
			post_two_q <= 3'd2;
			bypass_q   <= 1'b0;
			div_int_q  <= 24'd1;
			div_frac_q <= 16'd0;
		end else if (cfg_wr) begin
			case (pctc_pkg::reg_idx_t'(cfg_index))
				pctc_pkg::REG_CRYSTAL:  crystal_q  <= cfg_data;
				pctc_pkg::REG_REF_DIV:  ref_div_q  <= cfg_data[5:0];
				pctc_pkg::REG_FB_DIV:   fb_div_q   <= cfg_data[8:0];
				pctc_pkg::REG_POST_ONE: post_one_q <= cfg_data[2:0];
				pctc_pkg::REG_POST_TWO: post_two_q <= cfg_data[2:0];
				pctc_pkg::REG_BYPASS:   bypass_q   <= cfg_data[0];
				pctc_pkg::REG_DIV_INT:  div_int_q  <= cfg_data;
				pctc_pkg::REG_DIV_FRAC: div_frac_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// frequency calculation sequencer
	pctc_pkg::cal_state_t state_q, state_d;
	logic cal_busy;
	logic cal_step;

	logic [pctc_pkg::SNUM_W-1:0] dv_num_q;
	logic [pctc_pkg::SDEN_W-1:0] dv_den_q, dv_rem_q, dv_rem_d;
	logic [pctc_pkg::SCNT_W-1:0] dv_cnt_q;
	logic [pctc_pkg::SDEN_W:0]   dv_t;
	logic                        dv_ge;
	logic [pctc_pkg::SNUM_W-1:0] dv_quo;
	logic                        dv_last;

	logic [23:0]                   ref_hz_q;
	logic [pctc_pkg::VCO_W-1:0]    vco_q;
	logic [pctc_pkg::HZ_W-1:0]     src_q;
	logic [pctc_pkg::HZ_W-1:0]     hz_q;
	pctc_pkg::status_t             status_q, status_d;
	logic [pctc_pkg::SDEN_W-1:0]   sys_den;

	assign sys_den = (pctc_pkg::SDEN_W'(div_int_q) << pctc_pkg::FRAC_BITS)
		| pctc_pkg::SDEN_W'(div_frac_q);

	assign dv_t     = {dv_rem_q, dv_num_q[pctc_pkg::SNUM_W-1]};
	assign dv_ge    = dv_t >= {1'b0, dv_den_q};
	assign dv_rem_d = dv_ge ? pctc_pkg::SDEN_W'(dv_t - {1'b0, dv_den_q})
		: dv_t[pctc_pkg::SDEN_W-1:0];
	assign dv_quo   = {dv_num_q[pctc_pkg::SNUM_W-2:0], dv_ge};
	assign dv_last  = dv_cnt_q == pctc_pkg::SCNT_W'(pctc_pkg::SNUM_W - 1);

	always_comb begin
		state_d = state_q;
		if (cfg_wr) begin
			state_d = pctc_pkg::CAL_LOAD_REF;
		end else begin
			case (state_q)
				pctc_pkg::CAL_LOAD_REF: state_d = pctc_pkg::CAL_REF_DIV;
				pctc_pkg::CAL_REF_DIV:  if (dv_last) state_d = pctc_pkg::CAL_VCO;
				pctc_pkg::CAL_VCO:      state_d = pctc_pkg::CAL_POST_DIV;
				pctc_pkg::CAL_POST_DIV: if (dv_last) state_d = pctc_pkg::CAL_SYS_LOAD;
				pctc_pkg::CAL_SYS_LOAD: state_d = pctc_pkg::CAL_SYS_DIV;
				pctc_pkg::CAL_SYS_DIV:  if (dv_last) state_d = pctc_pkg::CAL_IDLE;
				pctc_pkg::CAL_IDLE:     state_d = pctc_pkg::CAL_IDLE;
				default:                state_d = pctc_pkg::CAL_LOAD_REF;
			endcase
		end
	end

	always_comb begin
		cal_busy = 1'b1;
		cal_step = 1'b0;
		case (state_q)
			pctc_pkg::CAL_REF_DIV,
			pctc_pkg::CAL_POST_DIV,
			pctc_pkg::CAL_SYS_DIV: cal_step = 1'b1;
			pctc_pkg::CAL_IDLE:    cal_busy = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pctc_pkg::CAL_LOAD_REF;
		else         state_q <= state_d;
	end

	// checks run in priority order; bypass skips the PLL checks
	always_comb begin
		status_d = pctc_pkg::ST_OK;
		if (crystal_q < pctc_pkg::CRYS_MIN_HZ || crystal_q > pctc_pkg::CRYS_MAX_HZ)
			status_d = pctc_pkg::ST_CRYSTAL;
		else if (div_int_q == 24'd0 || 25'(div_int_q) > 25'(pctc_pkg::DIV_INT_MAX)
			|| (div_frac_q >> pctc_pkg::FRAC_BITS) != 16'd0)
			status_d = pctc_pkg::ST_DIVIDER;
		else if (bypass_q)
			status_d = pctc_pkg::ST_OK;
		else if (ref_div_q == 6'd0 || ref_hz_q < pctc_pkg::REF_MIN_HZ)
			status_d = pctc_pkg::ST_REFDIV;
		else if (fb_div_q < pctc_pkg::FB_MIN || fb_div_q > pctc_pkg::FB_MAX)
			status_d = pctc_pkg::ST_FBDIV;
		else if (vco_q < pctc_pkg::VCO_W'(pctc_pkg::VCO_MIN_HZ)
			|| vco_q > pctc_pkg::VCO_W'(pctc_pkg::VCO_MAX_HZ))
			status_d = pctc_pkg::ST_VCO;
		else if (post_one_q == 3'd0 || post_two_q == 3'd0)
			status_d = pctc_pkg::ST_POSTDIV;
	end

	always_ff @(posedge clk) begin
		if (cal_step) begin
			dv_num_q <= dv_quo;
			dv_rem_q <= dv_rem_d;
			dv_cnt_q <= dv_cnt_q + 1'b1;
		end
		case (state_q)
			pctc_pkg::CAL_LOAD_REF: begin
				dv_num_q <= pctc_pkg::SNUM_W'(crystal_q);
				dv_den_q <= pctc_pkg::SDEN_W'(ref_div_q);
				dv_rem_q <= '0;
				dv_cnt_q <= '0;
			end
			pctc_pkg::CAL_REF_DIV: begin
				if (dv_last) ref_hz_q <= dv_quo[23:0];
			end
			pctc_pkg::CAL_VCO: begin
				vco_q    <= pctc_pkg::VCO_W'(ref_hz_q) * pctc_pkg::VCO_W'(fb_div_q);
				dv_num_q <= pctc_pkg::SNUM_W'(pctc_pkg::VCO_W'(ref_hz_q)
					* pctc_pkg::VCO_W'(fb_div_q));
				dv_den_q <= pctc_pkg::SDEN_W'(6'(post_one_q) * 6'(post_two_q));
				dv_rem_q <= '0;
				dv_cnt_q <= '0;
			end
			pctc_pkg::CAL_POST_DIV: begin
				if (dv_last)
					src_q <= bypass_q ? pctc_pkg::HZ_W'(crystal_q)
						: dv_quo[pctc_pkg::HZ_W-1:0];
			end
			pctc_pkg::CAL_SYS_LOAD: begin
				dv_num_q <= (pctc_pkg::SNUM_W'(src_q) << pctc_pkg::FRAC_BITS)
					+ pctc_pkg::SNUM_W'(sys_den >> 1);
				dv_den_q <= sys_den;
				dv_rem_q <= '0;
				dv_cnt_q <= '0;
			end
			pctc_pkg::CAL_SYS_DIV: begin
				if (dv_last) begin
					status_q <= status_d;
					hz_q     <= (status_d == pctc_pkg::ST_OK)
						? dv_quo[pctc_pkg::HZ_W-1:0] : '0;
				end
			end
			default: ;
		endcase
	end

	// conversion pipeline
	logic adv, take;
	logic rsp_valid_q;
	pctc_pkg::rsp_t rsp_q;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = cal_busy || !adv;
	assign take      = req_valid && !req_stall;

	logic [pctc_pkg::HZ_W-1:0] mul_d, add_d, den_d;
	always_comb begin
		case (pctc_pkg::op_t'(req.op))
			pctc_pkg::OP_TICKS_TO_NS: begin
				mul_d = pctc_pkg::NS_PER_S; den_d = hz_q; add_d = hz_q >> 1;
			end
			pctc_pkg::OP_TICKS_TO_US: begin
				mul_d = pctc_pkg::US_PER_S; den_d = hz_q; add_d = hz_q >> 1;
			end
			pctc_pkg::OP_NS_TO_TICKS: begin
				mul_d = hz_q; den_d = pctc_pkg::NS_PER_S;
				add_d = pctc_pkg::NS_PER_S - 1'b1;
			end
			default: begin
				mul_d = hz_q; den_d = pctc_pkg::US_PER_S;
				add_d = pctc_pkg::US_PER_S - 1'b1;
			end
		endcase
	end

	logic                          v_s1, v_s2, v_s3;
	logic [pctc_pkg::AMOUNT_W-1:0] amount_s1;
	logic [pctc_pkg::HZ_W-1:0]     mul_s1, add_s1, den_s1, add_s2, den_s2, den_s3;
	logic                          zero_s1, zero_s2, zero_s3;
	logic [pctc_pkg::PROD_W-1:0]   plo_s2, phi_s2;
	logic [pctc_pkg::DVD_W-1:0]    dvd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take) begin
				amount_s1 <= req.amount;
				mul_s1    <= mul_d;
				add_s1    <= add_d;
				den_s1    <= den_d;
				zero_s1   <= hz_q == '0;
			end
			plo_s2  <= pctc_pkg::PROD_W'(amount_s1[31:0]) * pctc_pkg::PROD_W'(mul_s1);
			phi_s2  <= pctc_pkg::PROD_W'(amount_s1[63:32]) * pctc_pkg::PROD_W'(mul_s1);
			add_s2  <= add_s1;
			den_s2  <= den_s1;
			zero_s2 <= zero_s1;
			dvd_s3  <= {phi_s2, 32'd0} + pctc_pkg::DVD_W'(plo_s2)
				+ pctc_pkg::DVD_W'(add_s2);
			den_s3  <= den_s2;
			zero_s3 <= zero_s2;
		end
	end

	// one quotient bit per stage
	function automatic pctc_pkg::dstage_t div_step(pctc_pkg::dstage_t s);
		logic [pctc_pkg::HZ_W:0] t;
		logic                    ge;
		pctc_pkg::dstage_t       o;
		t  = {s.rem, s.num[pctc_pkg::DVD_W-1]};
		ge = t >= {1'b0, s.den};
		o      = s;
		o.rem  = ge ? pctc_pkg::HZ_W'(t - {1'b0, s.den}) : t[pctc_pkg::HZ_W-1:0];
		o.num  = {s.num[pctc_pkg::DVD_W-2:0], ge};
		return o;
	endfunction

	logic              dvv_s [NST];
	pctc_pkg::dstage_t dvp_s [NST];
	pctc_pkg::dstage_t dv_in;

	always_comb begin
		dv_in.zero = zero_s3;
		dv_in.den  = den_s3;
		dv_in.rem  = '0;
		dv_in.num  = dvd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) dvv_s[k] <= 1'b0;
		end else if (adv) begin
			dvv_s[0] <= v_s3;
			for (int k = 1; k < NST; k++) dvv_s[k] <= dvv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvp_s[0] <= div_step(dv_in);
			for (int k = 1; k < NST; k++) dvp_s[k] <= div_step(dvp_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (adv) rsp_valid_q <= dvv_s[NST-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.converted <= dvp_s[NST-1].zero ? '0
				: dvp_s[NST-1].num[pctc_pkg::AMOUNT_W-1:0];
			rsp_q.overflow  <= !dvp_s[NST-1].zero
				&& (|dvp_s[NST-1].num[pctc_pkg::DVD_W-1:pctc_pkg::AMOUNT_W]);
			rsp_q.system_hz <= hz_q;
			rsp_q.status    <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sim/pctc_time_checker.sv]
`timescale 1ns / 100ps

module pctc_time_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  pctc_pkg::req_t   req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  pctc_pkg::rsp_t   rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	output int               fail_count,
	output int               pending_count
);
	import pctc_pkg::*;

	logic [23:0] crystal_hz;
	logic [5:0]  ref_div;
	logic [8:0]  fb_div;
	logic [2:0]  post_one;
	logic [2:0]  post_two;
	logic        bypass;
	logic [23:0] div_int;
	logic [15:0] div_frac;

	rsp_t expected_rsp[$];
	int   fails = 0;

	assign fail_count = fails;

	initial pending_count = 0;

	// Expected response for one conversion at the current tree setting.
	function automatic rsp_t convert_expected(input logic [1:0] op,
	                                          input logic [63:0] amount);
		logic [63:0]  ref_hz;
		logic [63:0]  vco;
		logic [63:0]  src;
		logic [63:0]  den;
		logic [63:0]  hz;
		logic [63:0]  scale;
		logic [63:0]  q;
		logic [63:0]  r;
		logic [63:0]  tail;
		logic [127:0] exact;
		status_t      st;
		rsp_t         o;
		hz = 64'd0;
		ref_hz = (ref_div == 6'd0) ? 64'd0 : 64'(crystal_hz) / 64'(ref_div);
		vco = ref_hz * 64'(fb_div);
		if (crystal_hz < 24'd1000000 || crystal_hz > 24'd15000000)
			st = ST_CRYSTAL;
		else if (div_int == 24'd0 || div_frac[15:FRAC_BITS] != '0)
			st = ST_DIVIDER;
		else if (bypass)
			st = ST_OK;
		else if (ref_div == 6'd0 || ref_hz < 64'd5000000)
			st = ST_REFDIV;
		else if (fb_div < 9'd16 || fb_div > 9'd320)
			st = ST_FBDIV;
		else if (vco < 64'(VCO_MIN_HZ) || vco > 64'(VCO_MAX_HZ))
			st = ST_VCO;
		else if (post_one == 3'd0 || post_two == 3'd0)
			st = ST_POSTDIV;
		else
			st = ST_OK;
		if (st == ST_OK) begin
			src = bypass ? 64'(crystal_hz) : vco / 64'(post_one) / 64'(post_two);
			den = (64'(div_int) << FRAC_BITS) | 64'(div_frac);
			hz  = ((src << FRAC_BITS) + den / 2) / den;
		end
		exact = '0;
		if (hz != 0) begin
			if (op == OP_TICKS_TO_NS || op == OP_TICKS_TO_US) begin
				scale = (op == OP_TICKS_TO_NS) ? 64'd1000000000 : 64'd1000000;
				q     = amount / hz;
				r     = amount % hz;
				tail  = (r * scale + hz / 2) / hz;
				exact = 128'(q) * 128'(scale) + 128'(tail);
			end else begin
				scale = (op == OP_NS_TO_TICKS) ? 64'd1000000000 : 64'd1000000;
				q     = amount / scale;
				r     = amount % scale;
				tail  = (r * hz + scale - 1) / scale;
				exact = 128'(q) * 128'(hz) + 128'(tail);
			end
		end
		o.converted = exact[63:0];
		o.system_hz = hz[HZ_W-1:0];
		o.status    = st;
		o.overflow  = (exact[127:64] != '0);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_hz <= 24'd12000000;
			ref_div    <= 6'd1;
			fb_div     <= 9'd125;
			post_one   <= 3'd6;
			post_two   <= 3'd2;
			bypass     <= 1'b0;
			div_int    <= 24'd1;
			div_frac   <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CRYSTAL:  crystal_hz <= cfg_data;
				REG_REF_DIV:  ref_div    <= cfg_data[5:0];
				REG_FB_DIV:   fb_div     <= cfg_data[8:0];
				REG_POST_ONE: post_one   <= cfg_data[2:0];
				REG_POST_TWO: post_two   <= cfg_data[2:0];
				REG_BYPASS:   bypass     <= cfg_data[0];
				REG_DIV_INT:  div_int    <= cfg_data;
				REG_DIV_FRAC: div_frac   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && req_valid && !req_stall)
			expected_rsp.push_back(convert_expected(req.op, req.amount));
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected response transaction %h", rsp);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.converted !== want.converted || rsp.system_hz !== want.system_hz ||
				    rsp.status !== want.status || rsp.overflow !== want.overflow) begin
					fails++;
					if (fails <= 10)
						$display({"mismatch: expected conv=%0d hz=%0d st=%0d ovf=%0b,",
						          " got conv=%0d hz=%0d st=%0d ovf=%0b"},
						         want.converted, want.system_hz, want.status, want.overflow,
						         rsp.converted, rsp.system_hz, rsp.status, rsp.overflow);
				end
			end
		end
		pending_count <= expected_rsp.size();
	end

endmodule

[sim/tb_pll_clock_tree_time_converter_unit.sv]
`timescale 1ns / 100ps

module tb_pll_clock_tree_time_converter_unit;
	import pctc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          cycles = 0;

	pll_clock_tree_time_converter_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pctc_time_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_count != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_tree(input logic [23:0] crys, input logic [5:0] refd,
	                        input logic [8:0] fb, input logic [2:0] p1, input logic [2:0] p2,
	                        input logic byp, input logic [23:0] dint, input logic [15:0] dfrac);
		wait_drained();
		write_reg(REG_CRYSTAL, crys);
		write_reg(REG_REF_DIV, 24'(refd));
		write_reg(REG_FB_DIV, 24'(fb));
		write_reg(REG_POST_ONE, 24'(p1));
		write_reg(REG_POST_TWO, 24'(p2));
		write_reg(REG_BYPASS, 24'(byp));
		write_reg(REG_DIV_INT, dint);
		write_reg(REG_DIV_FRAC, 24'(dfrac));
	endtask

	// Hold valid across back-to-back transactions; drop it only for an idle gap.
	task automatic send_conversion(input op_t op, input logic [63:0] amount);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req.op     <= op;
		req.amount <= amount;
		do @(posedge clk); while (req_stall);
	endtask

	function automatic logic [63:0] random_amount();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return v;
			1: return v >> $urandom_range(63);
			2: return ~(v >> $urandom_range(63, 8));
			default: return 64'($urandom_range(2000));
		endcase
	endfunction

	initial begin
		logic [23:0] crys;
		logic [5:0]  refd;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default tree at reset, then the edges of each operation
		send_conversion(OP_TICKS_TO_NS, 64'd0);
		send_conversion(OP_TICKS_TO_US, 64'd1);
		send_conversion(OP_NS_TO_TICKS, '1);
		send_conversion(OP_US_TO_TICKS, '1);
		send_conversion(OP_TICKS_TO_NS, '1);
		send_conversion(OP_US_TO_TICKS, 64'd1);
		req_valid <= 1'b0;
		// fastest legal system clock
		set_tree(24'd5000000, 6'd1, 9'd320, 3'd1, 3'd1, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, '1);
		send_conversion(OP_NS_TO_TICKS, '1);
		send_conversion(OP_TICKS_TO_US, 64'd1);
		req_valid <= 1'b0;
		set_tree(24'd15000000, 6'd3, 9'd150, 3'd7, 3'd7, 1'b0, 24'd3, 16'd128);
		send_conversion(OP_US_TO_TICKS, 64'd999999);
		req_valid <= 1'b0;
		set_tree(24'd15000000, 6'd0, 9'd0, 3'd0, 3'd0, 1'b1, 24'd1, 16'd255);
		send_conversion(OP_TICKS_TO_NS, 64'd12345);
		req_valid <= 1'b0;
		// bypass with the largest divider rounds the system clock down to zero
		set_tree(24'd1000000, 6'd1, 9'd125, 3'd6, 3'd2, 1'b1, 24'hFFFFFF, 16'd0);
		send_conversion(OP_NS_TO_TICKS, '1);
		req_valid <= 1'b0;
		// each failing check in order
		set_tree(24'd0, 6'd1, 9'd125, 3'd6, 3'd2, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, 64'd1000);
		req_valid <= 1'b0;
		set_tree(24'hFFFFFF, 6'd1, 9'd125, 3'd6, 3'd2, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_US, 64'd1000);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd1, 9'd125, 3'd6, 3'd2, 1'b0, 24'd0, 16'd0);
		send_conversion(OP_NS_TO_TICKS, 64'd1000);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd1, 9'd125, 3'd6, 3'd2, 1'b1, 24'd1, 16'hFFFF);
		send_conversion(OP_US_TO_TICKS, 64'd1000);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd0, 9'd125, 3'd6, 3'd2, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, 64'd7);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd63, 9'd125, 3'd6, 3'd2, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, 64'd7);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd1, 9'd511, 3'd6, 3'd2, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, 64'd7);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd1, 9'd16, 3'd6, 3'd2, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, 64'd7);
		req_valid <= 1'b0;
		set_tree(24'd12000000, 6'd1, 9'd125, 3'd0, 3'd7, 1'b0, 24'd1, 16'd0);
		send_conversion(OP_TICKS_TO_NS, 64'd7);
		req_valid <= 1'b0;

		for (int g = 0; g < 12; g++) begin
			if (g < 4) begin
				send_idle_pct = 20;
				recv_idle_pct = 47;
			end else if (g < 8) begin
				send_idle_pct = 47;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			crys = 24'($urandom_range(15000000, 5000000));
			refd = 6'($urandom_range(crys / 5000000, 1));
			if ($urandom_range(7) == 0)
				set_tree(24'($urandom), 6'($urandom), 9'($urandom), 3'($urandom),
				         3'($urandom), 1'($urandom), 24'($urandom), 16'($urandom));
			else
				set_tree(crys, refd, 9'($urandom_range(320, 16)), 3'($urandom_range(7, 1)),
				         3'($urandom_range(7, 1)), ($urandom_range(4) == 0),
				         ($urandom_range(5) == 0) ? 24'($urandom) : 24'($urandom_range(4, 1)),
				         16'($urandom_range(255)));
			for (int k = 0; k < 137; k++)
				send_conversion(op_t'($urandom_range(3)), random_amount());
			req_valid <= 1'b0;
		end

		wait_drained();
		if (fail_count == 0 && pending_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
rtl/pctc_pkg.sv
rtl/pll_clock_tree_time_converter_unit.sv
sim/pctc_time_checker.sv
sim/tb_pll_clock_tree_time_converter_unit.sv
